@@ hdl/tcis_pkg.sv @@
package tcis_pkg;

   // Default sizing of the block
   localparam int LANES_DEF    = 3;
   localparam int ETA_BITS_DEF = 12;
   localparam int PHI_BITS_DEF = 12;
   localparam int SUM_BITS_DEF = 16;

   // Fixed field widths
   localparam int WIN_BITS       = 12;
   localparam int PT_BITS        = 16;
   localparam int LIM_BITS       = 16;
   localparam int CSR_DATA_BITS  = 16;
   localparam int CSR_INDEX_BITS = 2;

   // Depth of the queue between front and back
   localparam int QUEUE_DEPTH = 2;

   // A track must sit strictly farther than this from the muon in both eta and phi
   localparam int DIST_FLOOR = 1;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_ETA_WINDOW = 2'd0,
      CSR_PHI_WINDOW = 2'd1,
      CSR_PT_MINIMUM = 2'd2,
      CSR_ISO_LIMIT  = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [WIN_BITS-1:0] eta_window;
      logic [WIN_BITS-1:0] phi_window;
      logic [PT_BITS-1:0]  pt_minimum;
      logic [LIM_BITS-1:0] iso_limit;
   } cfg_type;

endpackage

@@ hdl/tcis_ifs.sv @@
interface tcis_req_if import tcis_pkg::*; #(
   parameter int LANES    = LANES_DEF,
   parameter int ETA_BITS = ETA_BITS_DEF,
   parameter int PHI_BITS = PHI_BITS_DEF
);
   logic                      valid;
   logic                      ready;
   logic [ETA_BITS-1:0]       muon_eta;
   logic [PHI_BITS-1:0]       muon_phi;
   logic [LANES*ETA_BITS-1:0] lane_eta;
   logic [LANES*PHI_BITS-1:0] lane_phi;
   logic [LANES*PT_BITS-1:0]  lane_pt;
   logic                      final_group;

   modport source (output valid, muon_eta, muon_phi, lane_eta, lane_phi, lane_pt,
                   final_group, input ready);
   modport sink   (input valid, muon_eta, muon_phi, lane_eta, lane_phi, lane_pt,
                   final_group, output ready);
endinterface

interface tcis_rsp_if;
   logic valid;
   logic ready;
   logic isolated;

   modport source (output valid, isolated, input ready);
   modport sink   (input valid, isolated, output ready);
endinterface

@@ hdl/tcis_front.sv @@
module tcis_front import tcis_pkg::*; #(
   parameter int LANES    = LANES_DEF,
   parameter int ETA_BITS = ETA_BITS_DEF,
   parameter int PHI_BITS = PHI_BITS_DEF,
   parameter int TOT_BITS = PT_BITS + $clog2(LANES_DEF)
) (
   input  logic              clock,
   input  logic              reset,
   input  cfg_type           cfg,
   tcis_req_if.sink          req,
   output logic              push_valid,
   input  logic              push_ready,
   output logic [TOT_BITS:0] push_data
);

   localparam int ECMP = (ETA_BITS > WIN_BITS) ? ETA_BITS : WIN_BITS;
   localparam int PCMP = (PHI_BITS > WIN_BITS) ? PHI_BITS : WIN_BITS;

   logic                           s1_valid_ff;
   logic                           s1_final_ff;
   logic [LANES-1:0][PT_BITS-1:0]  s1_pt_ff;
   logic [LANES-1:0][PT_BITS-1:0]  qual_pt;
   logic [TOT_BITS-1:0]            total;
   logic                           accept;

   assign req.ready = !s1_valid_ff || push_ready;
   assign accept    = req.valid && req.ready;

   // Per-lane cone test: wrapped difference, magnitude, window and momentum cuts
   always_comb begin
      logic [ETA_BITS-1:0] deta_raw;
      logic [ETA_BITS-1:0] deta;
      logic [PHI_BITS-1:0] dphi_raw;
      logic [PHI_BITS-1:0] dphi;
      logic [PT_BITS-1:0]  pt;
      logic                eta_ok;
      logic                phi_ok;
      for (int k = 0; k < LANES; k++) begin
         deta_raw = req.lane_eta[k*ETA_BITS +: ETA_BITS] - req.muon_eta;
         dphi_raw = req.lane_phi[k*PHI_BITS +: PHI_BITS] - req.muon_phi;
         deta     = deta_raw[ETA_BITS-1] ? (ETA_BITS'(0) - deta_raw) : deta_raw;
         dphi     = dphi_raw[PHI_BITS-1] ? (PHI_BITS'(0) - dphi_raw) : dphi_raw;
         pt       = req.lane_pt[k*PT_BITS +: PT_BITS];
         eta_ok   = (ECMP'(deta) < ECMP'(cfg.eta_window)) && (deta > ETA_BITS'(DIST_FLOOR));
         phi_ok   = (PCMP'(dphi) < PCMP'(cfg.phi_window)) && (dphi > PHI_BITS'(DIST_FLOOR));
         qual_pt[k] = (eta_ok && phi_ok && (pt > cfg.pt_minimum)) ? pt : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req.ready) begin
         s1_valid_ff <= req.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pt_ff    <= qual_pt;
         s1_final_ff <= req.final_group;
      end
   end

   // Lane total of the counted momenta
   always_comb begin
      total = '0;
      for (int k = 0; k < LANES; k++) begin
         total = total + TOT_BITS'(s1_pt_ff[k]);
      end
   end

   assign push_valid = s1_valid_ff;
   assign push_data  = {s1_final_ff, total};

endmodule

@@ hdl/tcis_queue.sv @@
module tcis_queue import tcis_pkg::*; #(
   parameter int WIDTH = PT_BITS + 1,
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);

   localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS = $clog2(DEPTH + 1);

   logic [WIDTH-1:0]    mem_ff [DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff;
   logic [PTR_BITS-1:0] rd_ptr_ff;
   logic [CNT_BITS-1:0] count_ff;
   logic                push;
   logic                pop;

   assign push_ready = (count_ff != CNT_BITS'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = mem_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ hdl/tcis_back.sv @@
module tcis_back import tcis_pkg::*; #(
   parameter int SUM_BITS = SUM_BITS_DEF,
   parameter int TOT_BITS = PT_BITS + $clog2(LANES_DEF)
) (
   input  logic              clock,
   input  logic              reset,
   input  cfg_type           cfg,
   input  logic              pop_valid,
   output logic              pop_ready,
   input  logic [TOT_BITS:0] pop_data,
   tcis_rsp_if.source        rsp
);

   localparam int ADD_BITS = ((SUM_BITS > TOT_BITS) ? SUM_BITS : TOT_BITS) + 1;
   localparam int LCMP     = (SUM_BITS > LIM_BITS) ? SUM_BITS : LIM_BITS;
   localparam logic [SUM_BITS-1:0] SUM_MAX = '1;

   logic [SUM_BITS-1:0] acc_ff;
   logic                rsp_valid_ff;
   logic                iso_ff;
   logic                entry_final;
   logic [TOT_BITS-1:0] entry_total;
   logic [ADD_BITS-1:0] sum_wide;
   logic [SUM_BITS-1:0] sum_sat;
   logic                below;
   logic                out_free;
   logic                pop;

   assign entry_final = pop_data[TOT_BITS];
   assign entry_total = pop_data[TOT_BITS-1:0];

   // Saturating accumulate, then the isolation compare
   assign sum_wide = ADD_BITS'(acc_ff) + ADD_BITS'(entry_total);
   assign sum_sat  = (sum_wide > ADD_BITS'(SUM_MAX)) ? SUM_MAX : sum_wide[SUM_BITS-1:0];
   assign below    = LCMP'(sum_sat) < LCMP'(cfg.iso_limit);

   assign out_free  = !rsp_valid_ff || rsp.ready;
   assign pop_ready = !entry_final || out_free;
   assign pop       = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (pop) begin
            acc_ff <= entry_final ? '0 : sum_sat;
         end
         if (pop && entry_final) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop && entry_final) begin
         iso_ff <= below;
      end
   end

   assign rsp.valid    = rsp_valid_ff;
   assign rsp.isolated = iso_ff;

endmodule

@@ hdl/track_cone_isolation_sum.sv @@
// Channel    Direction  Moves per transaction
// req_chan   in         muon eta/phi, LANES tracks (eta, phi, pt), final_group
// rsp_chan   out        isolated, one per item with final_group set
// csr_*      in         write of one of four config registers, no read-back
//
// Takes one item per clock while req_chan ready is high; the front test stage and the
// accumulator each handle one transaction per cycle unless a downstream stall holds them.
// A result reaches rsp_chan through the front stage register, the queue and the output register.
// Reset clears the cone sum, the pipeline, the queue and all config registers.
// A stall on rsp_chan fills the two-entry queue, then holds req_chan ready low.
module track_cone_isolation_sum import tcis_pkg::*; #(
   parameter int LANES    = LANES_DEF,
   parameter int ETA_BITS = ETA_BITS_DEF,
   parameter int PHI_BITS = PHI_BITS_DEF,
   parameter int SUM_BITS = SUM_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_wr_en,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata,
   tcis_req_if.sink                  req_chan,
   tcis_rsp_if.source                rsp_chan
);

   // Lane total needs room for LANES full-scale momenta
   localparam int TOT_BITS = PT_BITS + $clog2(LANES);
   localparam int Q_WIDTH  = TOT_BITS + 1;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   logic               push_valid;
   logic               push_ready;
   logic [Q_WIDTH-1:0] push_data;
   logic               pop_valid;
   logic               pop_ready;
   logic [Q_WIDTH-1:0] pop_data;

   // Register file: decode the index, keep the low bits of the write data
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_ETA_WINDOW: cfg_in.eta_window = csr_wdata[WIN_BITS-1:0];
            CSR_PHI_WINDOW: cfg_in.phi_window = csr_wdata[WIN_BITS-1:0];
            CSR_PT_MINIMUM: cfg_in.pt_minimum = csr_wdata[PT_BITS-1:0];
            CSR_ISO_LIMIT:  cfg_in.iso_limit  = csr_wdata[LIM_BITS-1:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Front: accept a transaction, test every track against the cone, total the lanes
   tcis_front #(
      .LANES    (LANES),
      .ETA_BITS (ETA_BITS),
      .PHI_BITS (PHI_BITS),
      .TOT_BITS (TOT_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req        (req_chan),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   // Queue: decouple the front from output stalls
   tcis_queue #(
      .WIDTH (Q_WIDTH),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   // Back: accumulate, flag on the final group, hold the result until taken
   tcis_back #(
      .SUM_BITS (SUM_BITS),
      .TOT_BITS (TOT_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_data  (pop_data),
      .rsp       (rsp_chan)
   );

endmodule

@@ hdl/tcis_checker.sv @@
module tcis_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic req_final,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_isolated
);

   // Final items in flight: front stage, queue and output register
   localparam int PEND_MAX = 4;

   logic [2:0] pending_ff;
   logic       fin_acc;
   logic       rsp_acc;

   assign fin_acc = req_valid && req_ready && req_final;
   assign rsp_acc = rsp_valid && rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else if (fin_acc && !rsp_acc) begin
         pending_ff <= pending_ff + 1'b1;
      end else if (rsp_acc && !fin_acc) begin
         pending_ff <= pending_ff - 1'b1;
      end
   end

   a_reset_clears_rsp: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_rsp_has_source: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (pending_ff != 3'd0))
      else $error("result without an accepted final item");

   a_pending_bounded: assert property (@(posedge clock) disable iff (reset)
      pending_ff <= 3'(PEND_MAX))
      else $error("more final items in flight than storage");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_isolated))
      else $error("stalled result changed");

endmodule

bind track_cone_isolation_sum tcis_checker u_tcis_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_chan.valid),
   .req_ready    (req_chan.ready),
   .req_final    (req_chan.final_group),
   .rsp_valid    (rsp_chan.valid),
   .rsp_ready    (rsp_chan.ready),
   .rsp_isolated (rsp_chan.isolated)
);
